### hdl/lik_pkg.sv
// Shared types, constants and the arctangent table for the leg solver.
package lik_pkg;

    localparam int QDEPTH   = 4;
    localparam int QPTR_W   = 2;
    localparam int CORDIC_W = 52;
    localparam int ANG_W    = 32;
    localparam int CENT_W   = 18;

    localparam logic [2:0] CFG_HIP     = 3'd0;
    localparam logic [2:0] CFG_THIGH   = 3'd1;
    localparam logic [2:0] CFG_SHIN    = 3'd2;
    localparam logic [2:0] CFG_MOUNT_X = 3'd3;
    localparam logic [2:0] CFG_MOUNT_Y = 3'd4;
    localparam logic [2:0] CFG_MOUNT_Z = 3'd5;
    localparam logic [2:0] CFG_SIDE    = 3'd6;

    // floor(v / 10000) == (v * RECIP_K) >> RECIP_SH for v < 2^29
    localparam logic signed [31:0] RECIP_K  = 32'sd879609303;
    localparam int                 RECIP_SH = 43;
    localparam logic [29:0]        ROUND_HALF = 30'd5000;

    localparam logic signed [ANG_W-1:0] ANG_P90 = 32'sd90000000;
    localparam logic signed [ANG_W-1:0] ANG_M90 = -32'sd90000000;

    typedef struct packed {
        logic               leg_ok;
        logic               mirror;
        logic signed [16:0] x;
        logic signed [16:0] y;
        logic signed [16:0] z;
    } lik_item_t;

    // atan(2^-i) in 1e-6 degree, rounded
    function automatic logic [25:0] atan_entry(input logic [4:0] i);
        logic [25:0] v;
        case (i)
            5'd0:  v = 26'd45000000;
            5'd1:  v = 26'd26565051;
            5'd2:  v = 26'd14036243;
            5'd3:  v = 26'd7125016;
            5'd4:  v = 26'd3576334;
            5'd5:  v = 26'd1789911;
            5'd6:  v = 26'd895174;
            5'd7:  v = 26'd447614;
            5'd8:  v = 26'd223811;
            5'd9:  v = 26'd111906;
            5'd10: v = 26'd55953;
            5'd11: v = 26'd27976;
            5'd12: v = 26'd13988;
            5'd13: v = 26'd6994;
            5'd14: v = 26'd3497;
            5'd15: v = 26'd1749;
            5'd16: v = 26'd874;
            5'd17: v = 26'd437;
            5'd18: v = 26'd219;
            5'd19: v = 26'd109;
            5'd20: v = 26'd55;
            5'd21: v = 26'd27;
            5'd22: v = 26'd14;
            5'd23: v = 26'd7;
            default: v = 26'd0;
        endcase
        return v;
    endfunction

endpackage

### hdl/lik_front.sv
// Front end: accept targets, remove the leg mount offset, apply side mirror.
module lik_front #(
    parameter int LEG_COUNT = 4
) (
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    input  logic [47:0]             s_axis_tdata,  // target_x, target_y, target_z
    input  logic [1:0]              s_axis_tuser,  // leg
    input  logic [63:0]             mount_x_table,
    input  logic [63:0]             mount_y_table,
    input  logic [63:0]             mount_z_table,
    input  logic [3:0]              side_mirror_bits,
    input  logic                    queue_full,
    output logic                    push_valid,
    output lik_pkg::lik_item_t      push_item
);

    logic signed [15:0] tx, ty, tz, mx, my, mz;
    logic signed [16:0] dy;
    logic               mir;

    always_comb
    begin
        tx  = signed'(s_axis_tdata[15:0]);
        ty  = signed'(s_axis_tdata[31:16]);
        tz  = signed'(s_axis_tdata[47:32]);
        mx  = signed'(mount_x_table[{s_axis_tuser, 4'b0000} +: 16]);
        my  = signed'(mount_y_table[{s_axis_tuser, 4'b0000} +: 16]);
        mz  = signed'(mount_z_table[{s_axis_tuser, 4'b0000} +: 16]);
        mir = side_mirror_bits[s_axis_tuser];
        dy  = 17'(ty) - 17'(my);

        push_item.leg_ok = ({1'b0, s_axis_tuser} < 3'(LEG_COUNT));
        push_item.mirror = mir;
        push_item.x      = 17'(tx) - 17'(mx);
        push_item.y      = mir ? -dy : dy;
        push_item.z      = 17'(tz) - 17'(mz);
    end

    assign s_axis_tready = !queue_full;
    assign push_valid    = s_axis_tvalid && !queue_full;

endmodule

### hdl/lik_queue.sv
// Short queue between the front end and the solver.
module lik_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push_valid,
    input  lik_pkg::lik_item_t  push_item,
    output logic                full,
    input  logic                pop,
    output logic                head_valid,
    output lik_pkg::lik_item_t  head_item
);

    localparam int PW = lik_pkg::QPTR_W;

    lik_pkg::lik_item_t mem_reg [lik_pkg::QDEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [PW:0]   count_reg, count_next;
    logic          do_push, do_pop;

    assign full       = (count_reg == (PW+1)'(lik_pkg::QDEPTH));
    assign head_valid = (count_reg != '0);
    assign head_item  = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + (PW+1)'(do_push) - (PW+1)'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

### hdl/lik_back.sv
// Solver: sequenced square roots, division, CORDIC and rounding with one shared multiplier.
module lik_back #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_valid,
    input  lik_pkg::lik_item_t  q_item,
    output logic                q_pop,
    input  logic [14:0]         hip_offset_len,
    input  logic [14:0]         thigh_len,
    input  logic [14:0]         shin_len,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [47:0]         m_axis_tdata,  // shoulder_angle, knee_angle, yaw_angle
    output logic                m_axis_tuser   // reachable
);

    localparam int CW = lik_pkg::CORDIC_W;
    localparam int AW = lik_pkg::ANG_W;
    localparam int EW = lik_pkg::CENT_W;

    localparam logic [4:0] ST_IDLE  = 5'd0;
    localparam logic [4:0] ST_M0    = 5'd1;
    localparam logic [4:0] ST_M1    = 5'd2;
    localparam logic [4:0] ST_M2    = 5'd3;
    localparam logic [4:0] ST_ISQ   = 5'd4;
    localparam logic [4:0] ST_ISQD  = 5'd5;
    localparam logic [4:0] ST_N0    = 5'd6;
    localparam logic [4:0] ST_N1    = 5'd7;
    localparam logic [4:0] ST_N2    = 5'd8;
    localparam logic [4:0] ST_N3    = 5'd9;
    localparam logic [4:0] ST_N4    = 5'd10;
    localparam logic [4:0] ST_N5    = 5'd11;
    localparam logic [4:0] ST_DIV   = 5'd12;
    localparam logic [4:0] ST_Q0    = 5'd13;
    localparam logic [4:0] ST_Q1    = 5'd14;
    localparam logic [4:0] ST_P0    = 5'd15;
    localparam logic [4:0] ST_P1    = 5'd16;
    localparam logic [4:0] ST_P2    = 5'd17;
    localparam logic [4:0] ST_CINIT = 5'd18;
    localparam logic [4:0] ST_CIT   = 5'd19;
    localparam logic [4:0] ST_RD0   = 5'd20;
    localparam logic [4:0] ST_RDM   = 5'd21;
    localparam logic [4:0] ST_RD1   = 5'd22;
    localparam logic [4:0] ST_FIN   = 5'd23;
    localparam logic [4:0] ST_OUT   = 5'd24;

    logic [4:0]  state_reg, state_next;
    logic        out_valid_reg, out_valid_next;
    logic [4:0]  cnt_reg, cnt_next;

    logic signed [16:0] x_reg, x_next, y_reg, y_next, z_reg, z_next;
    logic               mirror_reg, mirror_next;
    logic signed [63:0] prod_reg, acc_reg, acc_next;
    logic [61:0]        isq_n_reg, isq_n_next, isq_res_reg, isq_res_next;
    logic [61:0]        isq_bit_reg, isq_bit_next;
    logic               second_reg, second_next;
    logic signed [22:0] u4_reg, u4_next;
    logic [39:0]        den_reg, den_next;
    logic [40:0]        rem_reg, rem_next;
    logic [30:0]        q_reg, q_next;
    logic               neg_reg, neg_next;
    logic signed [31:0] sd_reg, sd_next;
    logic [30:0]        s_reg, s_next;
    logic signed [CW-1:0] a2y_reg, a2y_next, a2x_reg, a2x_next;
    logic signed [CW-1:0] cx_reg, cx_next, cy_reg, cy_next;
    logic signed [AW-1:0] ang_reg, ang_next;
    logic [1:0]           ck_reg, ck_next, ri_reg, ri_next;
    logic signed [AW-1:0] slot_reg [4];
    logic signed [AW-1:0] slot_next [4];
    logic signed [EW-1:0] cent_reg [3];
    logic signed [EW-1:0] cent_next [3];
    logic [29:0]          mag_reg, mag_next;

    logic        res_reach_reg, res_reach_next;
    logic signed [16:0] res_sho_reg, res_sho_next;
    logic [14:0]        res_knee_reg, res_knee_next;
    logic signed [15:0] res_yaw_reg, res_yaw_next;

    logic        out_reach_reg, out_reach_next;
    logic signed [16:0] out_sho_reg, out_sho_next;
    logic [14:0]        out_knee_reg, out_knee_next;
    logic signed [15:0] out_yaw_reg, out_yaw_next;

    logic signed [31:0] mul_a, mul_b;
    logic signed [63:0] mul_p;

    // multiplier operand select
    always_comb
    begin
        case (state_reg)
            ST_M0:   begin mul_a = 32'(x_reg);  mul_b = 32'(x_reg);  end
            ST_M1:   begin mul_a = 32'(y_reg);  mul_b = 32'(y_reg);  end
            ST_N0:   begin mul_a = 32'(u4_reg); mul_b = 32'(u4_reg); end
            ST_N1:
            begin
                mul_a = 32'(signed'({z_reg, 4'b0000}));
                mul_b = mul_a;
            end
            ST_N2:
            begin
                mul_a = signed'(32'({thigh_len, 4'b0000}));
                mul_b = mul_a;
            end
            ST_N3:
            begin
                mul_a = signed'(32'({shin_len, 4'b0000}));
                mul_b = mul_a;
            end
            ST_N4:   begin mul_a = signed'(32'(thigh_len)); mul_b = signed'(32'(shin_len)); end
            ST_Q0:   begin mul_a = signed'(32'(q_reg)); mul_b = signed'(32'(q_reg)); end
            ST_P0:   begin mul_a = signed'(32'(shin_len)); mul_b = signed'(32'(s_reg)); end
            ST_P1:   begin mul_a = signed'(32'(shin_len)); mul_b = sd_reg; end
            ST_RDM:  begin mul_a = signed'(32'(mag_reg)); mul_b = lik_pkg::RECIP_K; end
            default: begin mul_a = '0; mul_b = '0; end
        endcase
        mul_p = 64'(mul_a) * 64'(mul_b);
    end

    logic [61:0]          isq_sum;
    logic                 isq_ge;
    logic [40:0]          rem2;
    logic [63:0]          nabs;
    logic [39:0]          den_w;
    logic signed [CW-1:0] ci_x, ci_y, dx, dy;
    logic signed [AW-1:0] atn, ang_step, v_sel;
    logic signed [EW-1:0] cq;
    logic signed [18:0]   knee_t;
    logic signed [EW-1:0] yaw_t;
    logic                 last_step;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        cnt_next       = cnt_reg;
        x_next = x_reg; y_next = y_reg; z_next = z_reg; mirror_next = mirror_reg;
        acc_next     = acc_reg;
        isq_n_next   = isq_n_reg;
        isq_res_next = isq_res_reg;
        isq_bit_next = isq_bit_reg;
        second_next  = second_reg;
        u4_next  = u4_reg;
        den_next = den_reg;
        rem_next = rem_reg;
        q_next   = q_reg;
        neg_next = neg_reg;
        sd_next  = sd_reg;
        s_next   = s_reg;
        a2y_next = a2y_reg;
        a2x_next = a2x_reg;
        cx_next  = cx_reg;
        cy_next  = cy_reg;
        ang_next = ang_reg;
        ck_next  = ck_reg;
        ri_next  = ri_reg;
        slot_next = slot_reg;
        cent_next = cent_reg;
        mag_next  = mag_reg;
        res_reach_next = res_reach_reg;
        res_sho_next   = res_sho_reg;
        res_knee_next  = res_knee_reg;
        res_yaw_next   = res_yaw_reg;
        out_reach_next = out_reach_reg;
        out_sho_next   = out_sho_reg;
        out_knee_next  = out_knee_reg;
        out_yaw_next   = out_yaw_reg;
        q_pop = 1'b0;

        isq_sum = isq_res_reg + isq_bit_reg;
        isq_ge  = (isq_n_reg >= isq_sum);
        rem2    = {rem_reg[39:0], 1'b0};
        nabs    = acc_reg[63] ? 64'(-acc_reg) : 64'(acc_reg);
        den_w   = {prod_reg[30:0], 9'b0};

        case (ck_reg)
            2'd0:
            begin
                ci_y = signed'(CW'(s_reg));
                ci_x = CW'(sd_reg);
            end
            2'd1:
            begin
                ci_y = -(CW'(signed'({z_reg, 4'b0000})) <<< 24);
                ci_x = CW'(u4_reg) <<< 24;
            end
            2'd2:
            begin
                ci_y = a2y_reg;
                ci_x = a2x_reg;
            end
            default:
            begin
                ci_y = CW'(x_reg) <<< 24;
                ci_x = CW'(y_reg) <<< 24;
            end
        endcase

        dx  = cy_reg >>> cnt_reg;
        dy  = cx_reg >>> cnt_reg;
        atn = signed'(AW'(lik_pkg::atan_entry(cnt_reg)));
        ang_step  = cy_reg[CW-1] ? ang_reg - atn : ang_reg + atn;
        last_step = (cnt_reg == 5'(CORDIC_STEPS - 1));

        case (ri_reg)
            2'd0:    v_sel = slot_reg[0];
            2'd1:    v_sel = slot_reg[1] - slot_reg[2];
            default: v_sel = slot_reg[3];
        endcase

        cq     = signed'(EW'(prod_reg[59:43]));
        knee_t = 19'sd18000 - 19'(cent_reg[0]);
        yaw_t  = mirror_reg ? -cent_reg[2] : cent_reg[2];

        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop       = 1'b1;
                    x_next      = q_item.x;
                    y_next      = q_item.y;
                    z_next      = q_item.z;
                    mirror_next = q_item.mirror;
                    if (q_item.leg_ok)
                    begin
                        state_next = ST_M0;
                    end
                    else
                    begin
                        res_reach_next = 1'b0;
                        res_sho_next   = '0;
                        res_knee_next  = '0;
                        res_yaw_next   = '0;
                        state_next     = ST_OUT;
                    end
                end
            end
            ST_M0: state_next = ST_M1;
            ST_M1:
            begin
                acc_next   = prod_reg;
                state_next = ST_M2;
            end
            ST_M2:
            begin
                isq_n_next   = 62'((acc_reg + prod_reg) <<< 8);
                isq_res_next = '0;
                isq_bit_next = 62'(1) << 60;
                second_next  = 1'b0;
                cnt_next     = '0;
                state_next   = ST_ISQ;
            end
            ST_ISQ:
            begin
                // one root bit per cycle
                isq_n_next   = isq_ge ? isq_n_reg - isq_sum : isq_n_reg;
                isq_res_next = isq_ge ? (isq_res_reg >> 1) + isq_bit_reg : isq_res_reg >> 1;
                isq_bit_next = isq_bit_reg >> 2;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == 5'd30)
                begin
                    state_next = ST_ISQD;
                end
            end
            ST_ISQD:
            begin
                if (second_reg)
                begin
                    s_next     = isq_res_reg[30:0];
                    state_next = ST_P0;
                end
                else
                begin
                    u4_next    = signed'(23'(isq_res_reg[20:0]))
                               - signed'(23'({hip_offset_len, 4'b0000}));
                    state_next = ST_N0;
                end
            end
            ST_N0: state_next = ST_N1;
            ST_N1:
            begin
                acc_next   = prod_reg;
                state_next = ST_N2;
            end
            ST_N2:
            begin
                acc_next   = acc_reg + prod_reg;
                state_next = ST_N3;
            end
            ST_N3:
            begin
                acc_next   = acc_reg - prod_reg;
                state_next = ST_N4;
            end
            ST_N4:
            begin
                acc_next   = acc_reg - prod_reg;
                state_next = ST_N5;
            end
            ST_N5:
            begin
                den_next = den_w;
                neg_next = acc_reg[63];
                rem_next = 41'(nabs);
                q_next   = '0;
                cnt_next = '0;
                if (den_w == '0 || nabs > 64'(den_w))
                begin
                    res_reach_next = 1'b0;
                    res_sho_next   = '0;
                    res_knee_next  = '0;
                    res_yaw_next   = '0;
                    state_next     = ST_OUT;
                end
                else if (nabs == 64'(den_w))
                begin
                    q_next     = 31'(1) << 30;
                    state_next = ST_Q0;
                end
                else
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                // one quotient bit per cycle
                if (rem2 >= {1'b0, den_reg})
                begin
                    rem_next = rem2 - {1'b0, den_reg};
                    q_next   = {q_reg[29:0], 1'b1};
                end
                else
                begin
                    rem_next = rem2;
                    q_next   = {q_reg[29:0], 1'b0};
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == 5'd29)
                begin
                    state_next = ST_Q0;
                end
            end
            ST_Q0:
            begin
                sd_next    = neg_reg ? -signed'(32'(q_reg)) : signed'(32'(q_reg));
                state_next = ST_Q1;
            end
            ST_Q1:
            begin
                isq_n_next   = (62'(1) << 60) - 62'(prod_reg);
                isq_res_next = '0;
                isq_bit_next = 62'(1) << 60;
                second_next  = 1'b1;
                cnt_next     = '0;
                state_next   = ST_ISQ;
            end
            ST_P0: state_next = ST_P1;
            ST_P1:
            begin
                a2y_next   = CW'(prod_reg);
                state_next = ST_P2;
            end
            ST_P2:
            begin
                a2x_next   = signed'(CW'({thigh_len, 30'b0})) + CW'(prod_reg);
                ck_next    = '0;
                state_next = ST_CINIT;
            end
            ST_CINIT:
            begin
                cnt_next = '0;
                if (ci_x == '0 && ci_y == '0)
                begin
                    slot_next[ck_reg] = '0;
                    if (ck_reg == 2'd3)
                    begin
                        ri_next    = '0;
                        state_next = ST_RD0;
                    end
                    else
                    begin
                        ck_next = ck_reg + 1'b1;
                    end
                end
                else
                begin
                    // fold the left half plane into the right one
                    if (ci_x[CW-1] && !ci_y[CW-1])
                    begin
                        cx_next  = ci_y;
                        cy_next  = -ci_x;
                        ang_next = lik_pkg::ANG_P90;
                    end
                    else if (ci_x[CW-1])
                    begin
                        cx_next  = -ci_y;
                        cy_next  = ci_x;
                        ang_next = lik_pkg::ANG_M90;
                    end
                    else
                    begin
                        cx_next  = ci_x;
                        cy_next  = ci_y;
                        ang_next = '0;
                    end
                    state_next = ST_CIT;
                end
            end
            ST_CIT:
            begin
                if (cy_reg[CW-1])
                begin
                    cx_next = cx_reg - dx;
                    cy_next = cy_reg + dy;
                end
                else
                begin
                    cx_next = cx_reg + dx;
                    cy_next = cy_reg - dy;
                end
                ang_next = ang_step;
                cnt_next = cnt_reg + 1'b1;
                if (last_step)
                begin
                    slot_next[ck_reg] = ang_step;
                    if (ck_reg == 2'd3)
                    begin
                        ri_next    = '0;
                        state_next = ST_RD0;
                    end
                    else
                    begin
                        ck_next    = ck_reg + 1'b1;
                        state_next = ST_CINIT;
                    end
                end
            end
            ST_RD0:
            begin
                neg_next   = v_sel[AW-1];
                mag_next   = 30'(v_sel[AW-1] ? -v_sel : v_sel) + lik_pkg::ROUND_HALF;
                state_next = ST_RDM;
            end
            ST_RDM: state_next = ST_RD1;
            ST_RD1:
            begin
                cent_next[ri_reg] = neg_reg ? -cq : cq;
                if (ri_reg == 2'd2)
                begin
                    state_next = ST_FIN;
                end
                else
                begin
                    ri_next    = ri_reg + 1'b1;
                    state_next = ST_RD0;
                end
            end
            ST_FIN:
            begin
                res_reach_next = 1'b1;
                if (cent_reg[1] < -18'sd36000)
                    res_sho_next = -17'sd36000;
                else if (cent_reg[1] > 18'sd18000)
                    res_sho_next = 17'sd18000;
                else
                    res_sho_next = 17'(cent_reg[1]);
                if (knee_t < 19'sd0)
                    res_knee_next = '0;
                else if (knee_t > 19'sd18000)
                    res_knee_next = 15'd18000;
                else
                    res_knee_next = 15'(knee_t);
                if (yaw_t < -18'sd18000)
                    res_yaw_next = -16'sd18000;
                else if (yaw_t > 18'sd18000)
                    res_yaw_next = 16'sd18000;
                else
                    res_yaw_next = 16'(yaw_t);
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_reach_next = res_reach_reg;
                    out_sho_next   = res_sho_reg;
                    out_knee_next  = res_knee_reg;
                    out_yaw_next   = res_yaw_reg;
                    state_next     = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg <= cnt_next;
        x_reg <= x_next; y_reg <= y_next; z_reg <= z_next; mirror_reg <= mirror_next;
        prod_reg    <= mul_p;
        acc_reg     <= acc_next;
        isq_n_reg   <= isq_n_next;
        isq_res_reg <= isq_res_next;
        isq_bit_reg <= isq_bit_next;
        second_reg  <= second_next;
        u4_reg  <= u4_next;
        den_reg <= den_next;
        rem_reg <= rem_next;
        q_reg   <= q_next;
        neg_reg <= neg_next;
        sd_reg  <= sd_next;
        s_reg   <= s_next;
        a2y_reg <= a2y_next;
        a2x_reg <= a2x_next;
        cx_reg  <= cx_next;
        cy_reg  <= cy_next;
        ang_reg <= ang_next;
        ck_reg  <= ck_next;
        ri_reg  <= ri_next;
        slot_reg <= slot_next;
        cent_reg <= cent_next;
        mag_reg  <= mag_next;
        res_reach_reg <= res_reach_next;
        res_sho_reg   <= res_sho_next;
        res_knee_reg  <= res_knee_next;
        res_yaw_reg   <= res_yaw_next;
        out_reach_reg <= out_reach_next;
        out_sho_reg   <= out_sho_next;
        out_knee_reg  <= out_knee_next;
        out_yaw_reg   <= out_yaw_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_reach_reg;
    assign m_axis_tdata  = {out_yaw_reg, out_knee_reg, out_sho_reg};

    a_unreach_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
        else $error("unreachable item carries nonzero angles");

    a_knee_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> out_knee_reg <= 15'd18000)
        else $error("knee angle above half turn");

    a_pop_busy: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |=> state_reg != ST_IDLE)
        else $error("solver idle right after taking an item");

    a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_OUT && (!out_valid_reg || m_axis_tready) |=> m_axis_tvalid)
        else $error("result not presented after load");

endmodule

### hdl/leg_inverse_kinematics_3dof_top.sv
// Top level of the three-link leg inverse kinematics block.
// Usage:
//   Input channel (s_axis_*): one item per foot target. tuser holds the leg
//   number, tdata holds target_x, target_y, target_z (signed, 0.1 mm).
//   Output channel (m_axis_*): one item per input item, in order. tuser is
//   the reachable flag, tdata holds shoulder, knee and yaw angles in 0.01 deg.
//   Config channel (cfg_*): register index plus 64-bit data, always ready;
//   write only while no item is in flight.
// Processing:
//   The solver works on one item at a time; a four-entry queue in front of it
//   takes items back to back while it runs. A reachable target goes through
//   two iterative square roots, an iterative division (skipped when the knee
//   cosine is exactly +-1), four CORDIC vectoring runs, then the multiplies,
//   rounding and handoff. The shared multiplier and the iterative root, divide
//   and CORDIC loops inside the solver set how long each item takes. A target
//   out of reach stops after the first root and the numerator; an item naming
//   a missing leg goes straight to the output register.
// Reset: clears the queue, solver and output valid; thigh = shin = 1000, rest 0.
// Back pressure: a result waits in the output register while m_axis_tready is
//   low; the solver stalls in ST_OUT, and s_axis_tready drops once the queue fills.
module leg_inverse_kinematics_3dof_top #(
    parameter int LEG_COUNT    = 4,
    parameter int CORDIC_STEPS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // target_x, target_y, target_z
    input  logic [1:0]  s_axis_tuser,   // leg
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // shoulder_angle, knee_angle, yaw_angle
    output logic        m_axis_tuser,   // reachable
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data
);

    logic [14:0] hip_reg, thigh_reg, shin_reg;
    logic [63:0] mx_reg, my_reg, mz_reg;
    logic [3:0]  side_reg;

    logic               push_valid, queue_full, head_valid, pop;
    lik_pkg::lik_item_t push_item, head_item;

    assign cfg_ready = 1'b1;

    // register file: writes beyond the list fall through untouched
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hip_reg   <= 15'd0;
            thigh_reg <= 15'd1000;
            shin_reg  <= 15'd1000;
            mx_reg    <= '0;
            my_reg    <= '0;
            mz_reg    <= '0;
            side_reg  <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                lik_pkg::CFG_HIP:     hip_reg   <= cfg_data[14:0];
                lik_pkg::CFG_THIGH:   thigh_reg <= cfg_data[14:0];
                lik_pkg::CFG_SHIN:    shin_reg  <= cfg_data[14:0];
                lik_pkg::CFG_MOUNT_X: mx_reg    <= cfg_data;
                lik_pkg::CFG_MOUNT_Y: my_reg    <= cfg_data;
                lik_pkg::CFG_MOUNT_Z: mz_reg    <= cfg_data;
                lik_pkg::CFG_SIDE:    side_reg  <= cfg_data[3:0];
                default:              ;
            endcase
        end
    end

    // front end: offset, mirror and leg check
    lik_front #(
        .LEG_COUNT(LEG_COUNT)
    ) u_front (
        .s_axis_tvalid    (s_axis_tvalid),
        .s_axis_tready    (s_axis_tready),
        .s_axis_tdata     (s_axis_tdata),
        .s_axis_tuser     (s_axis_tuser),
        .mount_x_table    (mx_reg),
        .mount_y_table    (my_reg),
        .mount_z_table    (mz_reg),
        .side_mirror_bits (side_reg),
        .queue_full       (queue_full),
        .push_valid       (push_valid),
        .push_item        (push_item)
    );

    // decouple intake from the solver
    lik_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_item  (push_item),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_item  (head_item)
    );

    // solver with its own output register
    lik_back #(
        .CORDIC_STEPS(CORDIC_STEPS)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_valid        (head_valid),
        .q_item         (head_item),
        .q_pop          (pop),
        .hip_offset_len (hip_reg),
        .thigh_len      (thigh_reg),
        .shin_len       (shin_reg),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata),
        .m_axis_tuser   (m_axis_tuser)
    );

endmodule

### test/tb_lik_checker.sv
// Checker for the leg solver: watches all three channels, predicts each result and compares.
`timescale 1ns / 100ps

module tb_lik_checker #(
    parameter int LEG_COUNT    = 4,
    parameter int CORDIC_STEPS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,
    input  logic [1:0]  s_axis_tuser,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [47:0] m_axis_tdata,
    input  logic        m_axis_tuser,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data,
    output int          errors,
    output int          pending
);

    typedef struct packed {
        logic        reach;
        logic [16:0] shoulder;
        logic [14:0] knee;
        logic [15:0] yaw;
    } joint_angles_t;

    localparam longint ATAN_STEP [24] = '{
        45000000, 26565051, 14036243, 7125016, 3576334, 1789911, 895174, 447614,
        223811, 111906, 55953, 27976, 13988, 6994, 3497, 1749,
        874, 437, 219, 109, 55, 27, 14, 7
    };

    logic [14:0] hip_len, thigh_len, shin_len;
    logic [63:0] mount_x, mount_y, mount_z;
    logic [3:0]  mirror_bits;

    joint_angles_t angle_fifo [$];

    function automatic longint unsigned int_sqrt(input longint unsigned val);
        longint unsigned root, bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > val)
            bitv >>= 2;
        while (bitv != 0)
        begin
            if (val >= root + bitv)
            begin
                val  = val - (root + bitv);
                root = (root >> 1) + bitv;
            end
            else
                root >>= 1;
            bitv >>= 2;
        end
        return root;
    endfunction

    // Vectoring rotation, angle in 1e-6 degree
    function automatic longint vector_angle(input longint yy, input longint xx);
        longint ang, t, dx, dy;
        ang = 0;
        if (xx == 0 && yy == 0)
            return 0;
        if (xx < 0)
        begin
            t = xx;
            if (yy >= 0)
            begin
                xx = yy; yy = -t; ang = 90000000;
            end
            else
            begin
                xx = -yy; yy = t; ang = -90000000;
            end
        end
        for (int i = 0; i < CORDIC_STEPS && i < 24; i++)
        begin
            dx = yy >>> i;
            dy = xx >>> i;
            if (yy >= 0)
            begin
                xx += dx; yy -= dy; ang += ATAN_STEP[i];
            end
            else
            begin
                xx -= dx; yy += dy; ang -= ATAN_STEP[i];
            end
        end
        return ang;
    endfunction

    function automatic longint centideg(input longint v);
        if (v >= 0)
            return (v + 5000) / 10000;
        return -((-v + 5000) / 10000);
    endfunction

    function automatic longint clamp(input longint v, input longint lo, input longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic joint_angles_t solve_leg(input logic [1:0] leg,
                                                input logic [47:0] tgt);
        longint x, y, z, u4, num, sd, ae, a1, a2, sho, kne, yaw, bb, cc, zz;
        longint unsigned r4, den, n, q, rem, s;
        joint_angles_t res;
        res = '0;
        if (int'(leg) >= LEG_COUNT)
            return res;
        x = longint'($signed(tgt[15:0]))  - longint'($signed(mount_x[16*leg +: 16]));
        y = longint'($signed(tgt[31:16])) - longint'($signed(mount_y[16*leg +: 16]));
        z = longint'($signed(tgt[47:32])) - longint'($signed(mount_z[16*leg +: 16]));
        if (mirror_bits[leg])
            y = -y;
        r4  = int_sqrt(longint'(x * x + y * y) << 8);
        u4  = longint'(r4) - 16 * longint'(hip_len);
        bb  = 16 * longint'(thigh_len);
        cc  = 16 * longint'(shin_len);
        zz  = 16 * z;
        num = u4 * u4 + zz * zz - bb * bb - cc * cc;
        den = 512 * longint'(thigh_len) * longint'(shin_len);
        n   = num < 0 ? -num : num;
        if (den == 0 || n > den)
            return res;
        if (n == den)
            q = 64'd1 << 30;
        else
        begin
            rem = n;
            q   = 0;
            for (int i = 0; i < 30; i++)
            begin
                rem <<= 1;
                q   <<= 1;
                if (rem >= den)
                begin
                    rem -= den;
                    q   |= 1;
                end
            end
        end
        sd = num < 0 ? -longint'(q) : longint'(q);
        s  = int_sqrt((64'd1 << 60) - q * q);
        ae = vector_angle(longint'(s), sd);
        a1 = vector_angle(-zz * 16777216, u4 * 16777216);
        a2 = vector_angle(longint'(shin_len) * longint'(s),
                          longint'(thigh_len) * (64'sd1 <<< 30) + longint'(shin_len) * sd);
        sho = clamp(centideg(a1 - a2), -36000, 18000);
        kne = clamp(18000 - centideg(ae), 0, 18000);
        yaw = centideg(vector_angle(x * 16777216, y * 16777216));
        if (mirror_bits[leg])
            yaw = -yaw;
        yaw = clamp(yaw, -18000, 18000);
        res.reach    = 1'b1;
        res.shoulder = sho[16:0];
        res.knee     = kne[14:0];
        res.yaw      = yaw[15:0];
        return res;
    endfunction

    assign pending = angle_fifo.size();

    always @(posedge clk or negedge rst_n)
    begin
        joint_angles_t want, got;
        if (!rst_n)
        begin
            hip_len     <= '0;
            thigh_len   <= 15'd1000;
            shin_len    <= 15'd1000;
            mount_x     <= '0;
            mount_y     <= '0;
            mount_z     <= '0;
            mirror_bits <= '0;
            errors      = 0;
            angle_fifo.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    lik_pkg::CFG_HIP:     hip_len     <= cfg_data[14:0];
                    lik_pkg::CFG_THIGH:   thigh_len   <= cfg_data[14:0];
                    lik_pkg::CFG_SHIN:    shin_len    <= cfg_data[14:0];
                    lik_pkg::CFG_MOUNT_X: mount_x     <= cfg_data;
                    lik_pkg::CFG_MOUNT_Y: mount_y     <= cfg_data;
                    lik_pkg::CFG_MOUNT_Z: mount_z     <= cfg_data;
                    lik_pkg::CFG_SIDE:    mirror_bits <= cfg_data[3:0];
                    default:              ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready)
                angle_fifo.push_back(solve_leg(s_axis_tuser, s_axis_tdata));
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.reach    = m_axis_tuser;
                got.shoulder = m_axis_tdata[16:0];
                got.knee     = m_axis_tdata[31:17];
                got.yaw      = m_axis_tdata[47:32];
                if (angle_fifo.size() == 0)
                begin
                    $display("%0t: unexpected result reach=%0b data=%h",
                             $time, m_axis_tuser, m_axis_tdata);
                    errors++;
                end
                else
                begin
                    want = angle_fifo.pop_front();
                    if (got.reach !== want.reach)
                    begin
                        $display("%0t: reachable expected %0b got %0b",
                                 $time, want.reach, got.reach);
                        errors++;
                    end
                    if (got.shoulder !== want.shoulder)
                    begin
                        $display("%0t: shoulder expected %0d got %0d", $time,
                                 $signed(want.shoulder), $signed(got.shoulder));
                        errors++;
                    end
                    if (got.knee !== want.knee)
                    begin
                        $display("%0t: knee expected %0d got %0d",
                                 $time, want.knee, got.knee);
                        errors++;
                    end
                    if (got.yaw !== want.yaw)
                    begin
                        $display("%0t: yaw expected %0d got %0d", $time,
                                 $signed(want.yaw), $signed(got.yaw));
                        errors++;
                    end
                end
            end
        end
    end

endmodule

### test/tb_leg_inverse_kinematics_3dof_top.sv
// Testbench top for the leg solver: stimulus, flow control and the verdict.
`timescale 1ns / 100ps

module tb_leg_inverse_kinematics_3dof_top;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata;   // target_x, target_y, target_z
    logic [1:0]  s_axis_tuser;   // leg
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [47:0] m_axis_tdata;   // shoulder_angle, knee_angle, yaw_angle
    logic        m_axis_tuser;   // reachable
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [63:0] cfg_data;

    int errors;
    int pending;
    int burst_left;
    bit want_hold;
    bit hold_taken;
    int hold_cycles;
    int stall_mode;

    leg_inverse_kinematics_3dof_top u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    tb_lik_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .errors        (errors),
        .pending       (pending)
    );

    initial
        clk = 1'b0;
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Result side: stall on its own pattern, switching between a stall-free
    // stretch, light stalls and heavy stalls. A long hold-off, once asked
    // for, is counted here so the block fills up and drops s_axis_tready.
    initial
    begin
        m_axis_tready = 1'b0;
        stall_mode    = 0;
        hold_cycles   = 0;
        hold_taken    = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (want_hold && !hold_taken)
            begin
                hold_taken  = 1'b1;
                hold_cycles = 2500;
            end
            if (hold_cycles > 0)
            begin
                hold_cycles--;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                if ($urandom_range(0, 199) == 0)
                    stall_mode = $urandom_range(0, 2);
                case (stall_mode)
                    0:       m_axis_tready <= 1'b1;
                    1:       m_axis_tready <= ($urandom_range(0, 3) != 0);
                    default: m_axis_tready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // Write every register, plus one index past the list that must be ignored.
    task automatic program_regs(input logic [14:0] hip, input logic [14:0] thigh,
                                input logic [14:0] shin, input logic [63:0] mx,
                                input logic [63:0] my, input logic [63:0] mz,
                                input logic [3:0] side);
        logic [63:0] vals [8];
        vals = '{{49'd0, hip}, {49'd0, thigh}, {49'd0, shin}, mx, my, mz,
                 {60'd0, side}, {$urandom, $urandom}};
        for (int i = 0; i < 8; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= i[2:0];
            cfg_data  <= vals[i];
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
        end
        cfg_valid <= 1'b0;
    endtask

    // Offer one item; bursts of random length separated by random gaps.
    task automatic send_target(input logic [1:0] leg, input logic [15:0] tx,
                               input logic [15:0] ty, input logic [15:0] tz);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= leg;
        s_axis_tdata  <= {tz, ty, tx};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        burst_left--;
    endtask

    // Drain: hold off new items until every result is back, then let the
    // solver settle before the next register write.
    task automatic drain;
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    function automatic logic [15:0] near_reach(input int span);
        int v;
        v = $urandom_range(0, 2 * span) - span;
        return v[15:0];
    endfunction

    initial
    begin
        logic [63:0] mx, my, mz;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        cfg_valid     = 1'b0;
        cfg_index     = lik_pkg::CFG_HIP;
        cfg_data      = '0;
        want_hold     = 1'b0;
        burst_left    = 0;
        rst_n         = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset defaults: b = c = 1000, no offsets. Directed targets.
        send_target(2'd0, 16'd0, 16'd0, 16'd0);                // folded, D = -1, zero atan2
        send_target(2'd1, 16'd2000, 16'd0, 16'd0);             // fully stretched, D = +1
        send_target(2'd2, 16'd0, 16'd2000, 16'd0);
        send_target(2'd3, 16'd0, 16'd0, -16'sd1500);
        send_target(2'd0, -16'sd1000, 16'd500, 16'd800);       // x negative
        send_target(2'd1, -16'sd700, -16'sd700, -16'sd300);
        send_target(2'd2, 16'd2001, 16'd0, 16'd0);             // just out of reach
        send_target(2'd3, 16'h7FFF, 16'h7FFF, 16'h7FFF);       // far corner
        send_target(2'd0, 16'h8000, 16'h8000, 16'h8000);
        send_target(2'd1, 16'd1, 16'd0, 16'd0);
        send_target(2'd2, 16'd0, 16'd0, 16'd1414);
        send_target(2'd3, 16'd1200, -16'sd900, 16'd600);
        drain();

        // Extreme offsets and link lengths, all legs mirrored.
        program_regs(15'h7FFF, 15'h7FFF, 15'h7FFF, 64'h7FFF_8000_7FFF_8000,
                     64'h8000_7FFF_8000_7FFF, 64'h7FFF_7FFF_8000_8000, 4'hF);
        send_target(2'd0, 16'h7FFF, 16'h7FFF, 16'h7FFF);
        send_target(2'd1, 16'h8000, 16'h8000, 16'h8000);
        send_target(2'd2, 16'h7FFF, 16'h8000, 16'h0000);
        send_target(2'd3, 16'h8000, 16'h7FFF, 16'hFFFF);
        for (int i = 0; i < 40; i++)
            send_target(2'($urandom_range(0, 3)), 16'($urandom), 16'($urandom),
                        16'($urandom));
        drain();

        // Zero thigh: every target unreachable.
        program_regs(15'd0, 15'd0, 15'd1000, 64'd0, 64'd0, 64'd0, 4'h5);
        for (int i = 0; i < 6; i++)
            send_target(2'($urandom_range(0, 3)), near_reach(2000), near_reach(2000),
                        near_reach(2000));
        drain();

        // Shortest links with a hip offset, tiny targets.
        program_regs(15'd1, 15'd1, 15'd1, 64'd0, 64'd0, 64'd0, 4'hA);
        for (int i = 0; i < 20; i++)
            send_target(2'($urandom_range(0, 3)), near_reach(4), near_reach(4),
                        near_reach(4));
        drain();

        // Typical geometry with random mounts; mostly targets within +-4500 of the
        // origin, some from the whole field range. Ask for one long result stall.
        for (int phase = 0; phase < 3; phase++)
        begin
            mx = '0;
            my = '0;
            mz = '0;
            for (int k = 0; k < 4; k++)
            begin
                mx[16*k +: 16] = near_reach(1000);
                my[16*k +: 16] = near_reach(1000);
                mz[16*k +: 16] = near_reach(1000);
            end
            program_regs(15'($urandom_range(0, 800)), 15'($urandom_range(800, 2000)),
                         15'($urandom_range(800, 2000)), mx, my, mz,
                         4'($urandom_range(0, 15)));
            if (phase == 1)
                want_hold = 1'b1;
            for (int i = 0; i < 100; i++)
            begin
                if ($urandom_range(0, 9) == 0)
                    send_target(2'($urandom_range(0, 3)), 16'($urandom), 16'($urandom),
                                16'($urandom));
                else
                    send_target(2'($urandom_range(0, 3)), near_reach(4500),
                                near_reach(4500), near_reach(4500));
            end
            drain();
        end

        if (errors == 0 && pending == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial
    begin
        #4000000;
        $display("FAILURE");
        $finish;
    end

endmodule

### filelist.f
hdl/lik_pkg.sv
hdl/lik_front.sv
hdl/lik_queue.sv
hdl/lik_back.sv
hdl/leg_inverse_kinematics_3dof_top.sv
test/tb_lik_checker.sv
test/tb_leg_inverse_kinematics_3dof_top.sv
